>>> design/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int COEF_W = 16;
  localparam int FRAC_W = 16;
  localparam int OUT_W  = 34;
  localparam int SQ_CELLS = OUT_W / 2;      // one root bit per cell
  localparam int ROOT_W = SQ_CELLS;
  localparam int SQ_REM_W = ROOT_W + 3;
  localparam int DEN_W = COEF_W + 1;
  localparam int DIV_CELLS = COEF_W + 1 + FRAC_W; // quotient bits
  localparam int NUM_W = DIV_CELLS;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_ONE   = 2'd1,
    ST_TWO   = 2'd2,
    ST_AZERO = 2'd3
  } status_t;

  // Fields that ride along with every item through the square root chain.
  typedef struct packed {
    status_t                   status;
    logic signed [OUT_W-1:0]   disc;
    logic signed [COEF_W-1:0]  b;
    logic                      a_neg;
    logic [DEN_W-1:0]          den;
  } info_t;

  // Square root cell state.
  typedef struct packed {
    info_t                 info;
    logic [OUT_W-1:0]      dsh;
    logic [SQ_REM_W-1:0]   rem;
    logic [ROOT_W-1:0]     root;
  } sq_t;

  // Two-lane divider cell state.
  typedef struct packed {
    status_t                  status;
    logic signed [OUT_W-1:0]  disc;
    logic                     neg_lo;
    logic                     neg_hi;
    logic [DEN_W-1:0]         den;
    logic [NUM_W-1:0]         nlo;
    logic [NUM_W-1:0]         nhi;
    logic [DEN_W-1:0]         rlo;
    logic [DEN_W-1:0]         rhi;
    logic [NUM_W-1:0]         qlo;
    logic [NUM_W-1:0]         qhi;
  } dv_t;

endpackage

>>> design/quadratic_root_solver_top.sv
// Throughput: one item per cycle while the output is not stalled; a chain of
// 17 square root cells and 33 two-lane divider cells each hold one item and
// pass it on every cycle that the pipeline is not stalled.
// The whole pipeline stalls only while the output item waits to be taken.
// Reset (rst, synchronous) clears every valid flag; data registers are not reset.
`timescale 1ns / 1ps
module quadratic_root_solver_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [qrs_pkg::COEF_W-1:0]      coef_a,
  input  logic signed [qrs_pkg::COEF_W-1:0]      coef_b,
  input  logic signed [qrs_pkg::COEF_W-1:0]      coef_c,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             root_status,
  output logic signed [qrs_pkg::OUT_W-1:0]       discriminant,
  output logic signed [qrs_pkg::OUT_W-1:0]       root_low_sign,
  output logic signed [qrs_pkg::OUT_W-1:0]       root_high_sign
);
  import qrs_pkg::*;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Stage one: products.
  logic                          p_valid;
  logic [2*COEF_W-1:0]           p_bb;
  logic signed [2*COEF_W-1:0]    p_ac;
  logic signed [COEF_W-1:0]      p_b;
  logic                          p_azero;
  logic                          p_aneg;
  logic [DEN_W-1:0]              p_den;
  logic [COEF_W-1:0]             a_mag;

  assign a_mag = coef_a[COEF_W-1] ? COEF_W'(-coef_a) : COEF_W'(coef_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_bb    <= (2*COEF_W)'(coef_b) * (2*COEF_W)'(coef_b);
      p_ac    <= (2*COEF_W)'(coef_a) * (2*COEF_W)'(coef_c);
      p_b     <= coef_b;
      p_azero <= (coef_a == '0);
      p_aneg  <= coef_a[COEF_W-1];
      p_den   <= {a_mag, 1'b0};
    end
  end

  // Stage two: discriminant and classification.
  logic signed [OUT_W-1:0] d_val;
  status_t                 d_status;
  sq_t                     sq_head;

  always_comb begin
    d_val = $signed({{(OUT_W-2*COEF_W){1'b0}}, p_bb})
          - ($signed(OUT_W'(p_ac)) <<< 2);
    if (p_azero) begin
      d_status = ST_AZERO;
    end else if (d_val[OUT_W-1]) begin
      d_status = ST_NONE;
    end else if (d_val == '0) begin
      d_status = ST_ONE;
    end else begin
      d_status = ST_TWO;
    end
  end

  logic q_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_head.info.status <= d_status;
      sq_head.info.disc   <= d_val;
      sq_head.info.b      <= p_b;
      sq_head.info.a_neg  <= p_aneg;
      sq_head.info.den    <= p_den;
      sq_head.dsh         <= d_val[OUT_W-1] ? '0 : d_val;
      sq_head.rem         <= '0;
      sq_head.root        <= '0;
    end
  end

  // Square root chain.
  sq_t  sq [0:SQ_CELLS];
  logic sv [0:SQ_CELLS];
  assign sq[0] = sq_head;
  assign sv[0] = q_valid;

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (sv[i]),
      .in_data  (sq[i]),
      .out_valid(sv[i+1]),
      .out_data (sq[i+1])
    );
  end

  // Numerators for both roots, split into sign and magnitude.
  sq_t                      sq_t_end;
  logic signed [ROOT_W+2:0] neg_b;
  logic signed [ROOT_W+2:0] num_lo;
  logic signed [ROOT_W+2:0] num_hi;
  logic [ROOT_W+2:0]        mag_lo;
  logic [ROOT_W+2:0]        mag_hi;
  dv_t                      dv_head;
  logic                     dh_valid;

  always_comb begin
    sq_t_end = sq[SQ_CELLS];
    neg_b  = -(ROOT_W+3)'(sq_t_end.info.b);
    num_lo = neg_b - $signed({3'b000, sq_t_end.root});
    num_hi = neg_b + $signed({3'b000, sq_t_end.root});
    mag_lo = num_lo[ROOT_W+2] ? (ROOT_W+3)'(-num_lo) : (ROOT_W+3)'(num_lo);
    mag_hi = num_hi[ROOT_W+2] ? (ROOT_W+3)'(-num_hi) : (ROOT_W+3)'(num_hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dh_valid <= 1'b0;
    end else if (en) begin
      dh_valid <= sv[SQ_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_head.status <= sq_t_end.info.status;
      dv_head.disc   <= sq_t_end.info.disc;
      dv_head.neg_lo <= num_lo[ROOT_W+2] ^ sq_t_end.info.a_neg;
      dv_head.neg_hi <= num_hi[ROOT_W+2] ^ sq_t_end.info.a_neg;
      dv_head.den    <= sq_t_end.info.den;
      dv_head.nlo    <= {mag_lo[NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      dv_head.nhi    <= {mag_hi[NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      dv_head.rlo    <= '0;
      dv_head.rhi    <= '0;
      dv_head.qlo    <= '0;
      dv_head.qhi    <= '0;
    end
  end

  // Divider chain.
  dv_t  dv [0:DIV_CELLS];
  logic dvv [0:DIV_CELLS];
  assign dv[0]  = dv_head;
  assign dvv[0] = dh_valid;

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_dv
    qrs_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dvv[j]),
      .in_data  (dv[j]),
      .out_valid(dvv[j+1]),
      .out_data (dv[j+1])
    );
  end

  // Apply signs, zero the unused roots and register the output item.
  dv_t                     dv_end;
  logic signed [OUT_W-1:0] lo_val;
  logic signed [OUT_W-1:0] hi_val;

  always_comb begin
    dv_end = dv[DIV_CELLS];
    lo_val = dv_end.neg_lo ? -$signed(OUT_W'(dv_end.qlo)) : $signed(OUT_W'(dv_end.qlo));
    hi_val = dv_end.neg_hi ? -$signed(OUT_W'(dv_end.qhi)) : $signed(OUT_W'(dv_end.qhi));
    if (dv_end.status == ST_NONE || dv_end.status == ST_AZERO) begin
      lo_val = '0;
    end
    if (dv_end.status != ST_TWO) begin
      hi_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvv[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_status    <= dv_end.status;
      discriminant   <= dv_end.disc;
      root_low_sign  <= lo_val;
      root_high_sign <= hi_val;
    end
  end

  // Checks.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (root_status == ST_NONE || root_status == ST_AZERO)
      |-> root_low_sign == '0 && root_high_sign == '0)
    else $error("roots not zero without real roots");

  a_one_disc: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_status == ST_ONE |-> discriminant == '0 && root_high_sign == '0)
    else $error("single root item inconsistent");

  a_neg_disc: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_status == ST_NONE |-> discriminant[OUT_W-1])
    else $error("no-root status with non-negative discriminant");

  a_two_disc: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_status == ST_TWO |-> !discriminant[OUT_W-1] && discriminant != '0)
    else $error("two-root status with non-positive discriminant");
endmodule

>>> design/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
module qrs_sqrt_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  qrs_pkg::sq_t in_data,
  output logic         out_valid,
  output qrs_pkg::sq_t out_data
);
  import qrs_pkg::*;

  logic [SQ_REM_W-1:0] rem_sh;
  logic [SQ_REM_W-1:0] trial;
  sq_t                 res;

  // One restoring step: bring in two radicand bits, try the next root bit.
  always_comb begin
    rem_sh = {in_data.rem[SQ_REM_W-3:0], in_data.dsh[OUT_W-1 -: 2]};
    trial  = {1'b0, in_data.root, 2'b01};
    res = in_data;
    res.dsh = {in_data.dsh[OUT_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      res.rem  = rem_sh - trial;
      res.root = {in_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = rem_sh;
      res.root = {in_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end
endmodule

>>> design/qrs_div_cell.sv
`timescale 1ns / 1ps
module qrs_div_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  qrs_pkg::dv_t in_data,
  output logic         out_valid,
  output qrs_pkg::dv_t out_data
);
  import qrs_pkg::*;

  logic [DEN_W:0] sh_lo;
  logic [DEN_W:0] sh_hi;
  logic [DEN_W:0] den_x;
  dv_t            res;

  // One quotient bit for each of the two roots.
  always_comb begin
    den_x = {1'b0, in_data.den};
    sh_lo = {in_data.rlo, in_data.nlo[NUM_W-1]};
    sh_hi = {in_data.rhi, in_data.nhi[NUM_W-1]};
    res = in_data;
    res.nlo = {in_data.nlo[NUM_W-2:0], 1'b0};
    res.nhi = {in_data.nhi[NUM_W-2:0], 1'b0};
    if (sh_lo >= den_x) begin
      res.rlo = DEN_W'(sh_lo - den_x);
      res.qlo = {in_data.qlo[NUM_W-2:0], 1'b1};
    end else begin
      res.rlo = sh_lo[DEN_W-1:0];
      res.qlo = {in_data.qlo[NUM_W-2:0], 1'b0};
    end
    if (sh_hi >= den_x) begin
      res.rhi = DEN_W'(sh_hi - den_x);
      res.qhi = {in_data.qhi[NUM_W-2:0], 1'b1};
    end else begin
      res.rhi = sh_hi[DEN_W-1:0];
      res.qhi = {in_data.qhi[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end
endmodule

>>> dv/quadratic_root_checker.sv
`timescale 1ns / 1ps
module quadratic_root_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [qrs_pkg::COEF_W-1:0]  coef_a,
  input  logic signed [qrs_pkg::COEF_W-1:0]  coef_b,
  input  logic signed [qrs_pkg::COEF_W-1:0]  coef_c,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [1:0]                         root_status,
  input  logic signed [qrs_pkg::OUT_W-1:0]   discriminant,
  input  logic signed [qrs_pkg::OUT_W-1:0]   root_low_sign,
  input  logic signed [qrs_pkg::OUT_W-1:0]   root_high_sign,
  output int                                 errors,
  output int                                 pending,
  output int                                 results_seen
);
  import qrs_pkg::*;

  typedef struct packed {
    status_t                 status;
    logic signed [OUT_W-1:0] disc;
    logic signed [OUT_W-1:0] lo;
    logic signed [OUT_W-1:0] hi;
  } roots_t;

  roots_t expected_roots[$];

  // Integer square root, floored, by the usual bit-pair method.
  function automatic longint floor_sqrt(longint n);
    longint r;
    longint bitv;
    r = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >>> 1) + bitv;
      end else begin
        r = r >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return r;
  endfunction

  // Fixed point quotient, truncated toward zero and saturated to the output.
  function automatic longint scaled_quotient(longint num, longint den);
    longint q;
    longint top;
    top = (64'sd1 <<< (OUT_W - 1)) - 1;
    q = (num * (64'sd1 <<< FRAC_W)) / den;
    if (q > top) q = top;
    if (q < -top - 1) q = -top - 1;
    return q;
  endfunction

  function automatic roots_t solve_quadratic(longint a, longint b, longint c);
    roots_t r;
    longint d;
    longint s;
    d = b * b - 4 * a * c;
    r.disc = d[OUT_W-1:0];
    r.lo = '0;
    r.hi = '0;
    if (a == 0) begin
      r.status = ST_AZERO;
    end else if (d < 0) begin
      r.status = ST_NONE;
    end else if (d == 0) begin
      r.status = ST_ONE;
      r.lo = OUT_W'(scaled_quotient(-b, 2 * a));
    end else begin
      s = floor_sqrt(d);
      r.status = ST_TWO;
      r.lo = OUT_W'(scaled_quotient(-b - s, 2 * a));
      r.hi = OUT_W'(scaled_quotient(-b + s, 2 * a));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Predict on each accepted item and compare each accepted result.
  always @(posedge clk) begin
    roots_t want;
    if (rst) begin
      errors = 0;
      results_seen = 0;
      pending = 0;
    end else begin
      if (in_valid && in_ready)
        expected_roots.push_back(solve_quadratic(coef_a, coef_b, coef_c));
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected result, status", root_status, -1);
        end else begin
          want = expected_roots.pop_front();
          if (root_status != want.status)
            report_mismatch("root_status", root_status, want.status);
          if (discriminant != want.disc)
            report_mismatch("discriminant", discriminant, want.disc);
          if (root_low_sign != want.lo)
            report_mismatch("root_low_sign", root_low_sign, want.lo);
          if (root_high_sign != want.hi)
            report_mismatch("root_high_sign", root_high_sign, want.hi);
        end
      end
      pending = expected_roots.size();
    end
  end
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import qrs_pkg::*;

  localparam int RANDOM_ITEMS = 610;
  localparam int TAIL_ITEMS = 120;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COEF_W-1:0] coef_a = '0;
  logic signed [COEF_W-1:0] coef_b = '0;
  logic signed [COEF_W-1:0] coef_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] root_status;
  logic signed [OUT_W-1:0] discriminant;
  logic signed [OUT_W-1:0] root_low_sign;
  logic signed [OUT_W-1:0] root_high_sign;
  int errors;
  int pending;
  int results_seen;
  int items_sent = 0;
  bit calm = 1'b0;
  longint cycles = 0;

  always #5 clk = ~clk;

  quadratic_root_solver_top dut (.*);

  quadratic_root_checker checker_i (.*);

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending", cycles, pending);
      $display("quadratic_root_solver_top: mismatch");
      $finish;
    end
  end

  // The receiver stalls in bursts until the calm tail.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Present one item and hold it until accepted.
  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    in_valid <= 1'b1;
    @(posedge clk iff in_ready);
    @(negedge clk);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      3: return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int k;
    logic [15:0] r1;
    logic [15:0] r2;
    logic [15:0] sc;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners: a zero, double roots, no roots, two roots, extremes.
    send_coefs(16'd0, 16'd5, 16'd3);
    send_coefs(16'd0, 16'h8000, 16'h7fff);
    send_coefs(16'd0, 16'd0, 16'd0);
    send_coefs(16'd1, 16'd2, 16'd1);
    send_coefs(16'hffff, 16'd4, 16'hfffc);
    send_coefs(16'd1, 16'd0, 16'd1);
    send_coefs(16'd1, 16'd0, 16'hffff);
    send_coefs(16'd1, 16'hfffd, 16'd2);
    send_coefs(16'd2, 16'd3, 16'hfffb);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff);
    send_coefs(16'h7fff, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h0000, 16'h7fff);
    send_coefs(16'h7fff, 16'h0000, 16'h8000);
    send_coefs(16'h0001, 16'h8000, 16'h0000);
    send_coefs(16'hffff, 16'h7fff, 16'h0000);
    send_coefs(16'h0001, 16'hffff, 16'h7fff);
    send_coefs(16'h4000, 16'h8000, 16'h4000);

    // Hold the sender until the pipeline has drained.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    // Random items; about a third are built from integer roots so that
    // double and two-root cases with exact values are common.
    for (k = 0; k < RANDOM_ITEMS + TAIL_ITEMS; k++) begin
      if (k == RANDOM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        sc = 16'($signed($urandom_range(1, 6)) * ($urandom_range(0, 1) ? 1 : -1));
        r1 = 16'($signed($urandom_range(0, 60)) - 30);
        r2 = ($urandom_range(0, 3) == 0) ? r1 : 16'($signed($urandom_range(0, 60)) - 30);
        send_coefs(sc, 16'(-$signed(sc) * ($signed(r1) + $signed(r2))),
                   16'($signed(sc) * $signed(r1) * $signed(r2)));
      end else begin
        send_coefs(pick_coef(), pick_coef(), pick_coef());
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Sent %0d coefficient sets, %0d results checked, covering all four", items_sent,
             results_seen);
    $display("root classes, extreme coefficients and random stalls on both sides.");
    if (errors == 0) begin
      $display("quadratic_root_solver_top: match");
    end else begin
      $display("quadratic_root_solver_top: mismatch");
    end
    $finish;
  end
endmodule
